FILE: hdl/char_to_tone_fsk_generator_top_assert.svh
// assertion macros used by the tone generator top
// expects signals named clk and rst_n in the including module
`ifndef CHAR_TO_TONE_FSK_GENERATOR_TOP_ASSERT_SVH
`define CHAR_TO_TONE_FSK_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CTFSK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CTFSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ctfsk_pkg.sv
// shared types and constants of the text-to-tone generator
// fixed-point quarter-sine helpers used to build the sine rom at elaboration
package ctfsk_pkg;

  localparam int OP_W      = 3;
  localparam int CODE_W    = 8;
  localparam int STEP_W    = 32;
  localparam int LEN_W     = 20;
  localparam int AMP_W     = 15;
  localparam int SAMPLE_W  = 16;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_SYMBOL = 3'd1,
    OP_START  = 3'd2,
    OP_END    = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  localparam logic [REG_IDX_W-1:0] REG_TONE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYNC    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_AMP     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END     = 3'd5;

  localparam logic [LEN_W-1:0]  TONE_RST    = 20'd4800;
  localparam logic [LEN_W-1:0]  SILENCE_RST = 20'd2400;
  localparam logic [LEN_W-1:0]  SYNC_RST    = 20'd0;
  localparam logic [AMP_W-1:0]  AMP_RST     = 15'd16000;
  localparam logic [STEP_W-1:0] STEP_RST    = 32'd0;

  // status flags of one result transaction
  typedef struct packed {
    logic sample_valid;
    logic symbol_last;
    logic accepted;
    logic busy_res;
  } res_flags_t;

  function automatic logic [63:0] q30mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  // sin(pi/2 * u) in q30, u in [0, 1] as q30, odd polynomial in horner form
  function automatic logic [63:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] p;
    u2 = q30mul(u, u);
    p  = 64'd172272 - q30mul(u2, 64'd3864);
    p  = 64'd5026995 - q30mul(u2, p);
    p  = 64'd85569306 - q30mul(u2, p);
    p  = 64'd693598668 - q30mul(u2, p);
    p  = 64'd1686629713 - q30mul(u2, p);
    return q30mul(u, p);
  endfunction

endpackage

FILE: hdl/ctfsk_sine.sv
// dds sample shaper: quarter-wave sine rom, amplitude multiply, sign restore
// depends on ctfsk_pkg; two register stages, advancing with en
module ctfsk_sine #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 tone_in,
  input  logic [SINE_ADDR_BITS-1:0]            addr_in,
  input  logic [ctfsk_pkg::AMP_W-1:0]          amplitude,
  output logic signed [ctfsk_pkg::SAMPLE_W-1:0] sample
);
  import ctfsk_pkg::*;

  localparam int Q     = SINE_ADDR_BITS - 2;
  localparam int QSIZE = 1 << Q;
  localparam int PROD_W = AMP_W + SAMPLE_W;

  typedef logic [SAMPLE_W-1:0] rom_t [QSIZE+1];

  // magnitude in q15, rounded and limited to 32768
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] m;
    for (int i = 0; i <= QSIZE; i++) begin
      u = 64'(i) << (30 - Q);
      s = quarter_sine(u);
      m = (s + 64'd16384) >> 15;
      if (m > 64'd32768) m = 64'd32768;
      rom[i] = SAMPLE_W'(m);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [1:0]        quad;
  logic [Q-1:0]      frac;
  logic [Q:0]        pos;
  logic [SAMPLE_W-1:0] m_r;
  logic              neg1_r;
  logic              tone1_r;
  logic [PROD_W-1:0] prod;
  logic [SAMPLE_W-1:0] mag_r;
  logic              neg2_r;
  logic              tone2_r;

  assign quad = addr_in[SINE_ADDR_BITS-1 -: 2];
  assign frac = addr_in[Q-1:0];
  // second and fourth quadrants run the quarter wave backwards
  assign pos  = quad[0] ? ((Q+1)'(QSIZE) - {1'b0, frac}) : {1'b0, frac};

  always_ff @(posedge clk) begin
    if (en) begin
      m_r     <= SINE_ROM[pos];
      neg1_r  <= quad[1];
      tone1_r <= tone_in;
    end
  end

  assign prod = PROD_W'(amplitude) * PROD_W'(m_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= prod[PROD_W-1 -: SAMPLE_W];
      neg2_r  <= neg1_r;
      tone2_r <= tone1_r;
    end
  end

  always_comb begin
    if (!tone2_r) begin
      sample = '0;
    end else if (neg2_r) begin
      sample = $signed(-mag_r);
    end else begin
      sample = $signed(mag_r);
    end
  end

endmodule

FILE: hdl/char_to_tone_fsk_generator_top.sv
// Text-to-tone encoder: every input transaction (table write, character, start or end
// marker, sample tick) yields exactly one result transaction, through stages one to
// three and the output register. One transaction is taken per clock unless the input
// is stalled: the player state (phase, tone and gap counters, active step) is read,
// modified and written back in the same cycle, and the step table is a single-port
// synchronous memory written when a write is taken and read on every advance, its
// data ready in the next cycle. Table entries have valid bits cleared by reset, so
// the block is usable directly after reset. The sine path (rom read, amplitude
// multiply) adds two stages behind the state update. Input stall follows the output
// register: it rises only while a result waits. Depends on ctfsk_pkg and ctfsk_sine.
module char_to_tone_fsk_generator_top #(
  parameter int TABLE_DEPTH    = 256,
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int COUNT_BITS     = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ctfsk_pkg::OP_W-1:0]            in_opcode,
  input  logic [ctfsk_pkg::CODE_W-1:0]          in_symbol_code,
  input  logic [ctfsk_pkg::STEP_W-1:0]          in_table_step,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ctfsk_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                  out_sample_valid,
  output logic                                  out_symbol_last,
  output logic                                  out_accepted,
  output logic                                  out_busy_res,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ctfsk_pkg::PADDR_W-1:0]         paddr,
  input  logic [ctfsk_pkg::PDATA_W-1:0]         pwdata,
  output logic [ctfsk_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready
);
  import ctfsk_pkg::*;

  localparam int IDX_BITS = $clog2(TABLE_DEPTH);

  // configuration registers
  logic [LEN_W-1:0]  tone_samples_r;
  logic [LEN_W-1:0]  silence_samples_r;
  logic [LEN_W-1:0]  sync_samples_r;
  logic [AMP_W-1:0]  amplitude_r;
  logic [STEP_W-1:0] start_step_r;
  logic [STEP_W-1:0] end_step_r;
  logic              cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_samples_r    <= TONE_RST;
      silence_samples_r <= SILENCE_RST;
      sync_samples_r    <= SYNC_RST;
      amplitude_r       <= AMP_RST;
      start_step_r      <= STEP_RST;
      end_step_r        <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TONE:    tone_samples_r    <= pwdata[LEN_W-1:0];
        REG_SILENCE: silence_samples_r <= pwdata[LEN_W-1:0];
        REG_SYNC:    sync_samples_r    <= pwdata[LEN_W-1:0];
        REG_AMP:     amplitude_r       <= pwdata[AMP_W-1:0];
        REG_START:   start_step_r      <= pwdata;
        REG_END:     end_step_r        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TONE:    prdata = PDATA_W'(tone_samples_r);
      REG_SILENCE: prdata = PDATA_W'(silence_samples_r);
      REG_SYNC:    prdata = PDATA_W'(sync_samples_r);
      REG_AMP:     prdata = PDATA_W'(amplitude_r);
      REG_START:   prdata = start_step_r;
      REG_END:     prdata = end_step_r;
      default:     prdata = '0;
    endcase
  end

  // pipeline advance: everything moves unless a finished result is held
  logic adv;
  logic in_acc;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // step table: memory plus per-entry valid bits
  logic [PHASE_BITS-1:0] step_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_r;
  logic [IDX_BITS-1:0]   tbl_idx;
  logic                  in_range;
  logic                  tbl_we;

  assign tbl_idx  = in_symbol_code[IDX_BITS-1:0];
  assign in_range = (9'(in_symbol_code) < 9'(TABLE_DEPTH));
  assign tbl_we   = in_acc && (op_t'(in_opcode) == OP_WRITE) && in_range;

  logic [PHASE_BITS-1:0] rd_data_r;
  logic                  rd_hit_r;
  logic                  s1_v_r;
  op_t                   s1_op_r;
  logic                  s1_range_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      step_mem[tbl_idx] <= in_table_step[PHASE_BITS-1:0];
    end
    if (adv) begin
      rd_data_r <= step_mem[tbl_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (tbl_we) begin
      tbl_vld_r[tbl_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= op_t'(in_opcode);
      s1_range_r <= in_range;
      rd_hit_r   <= in_range && tbl_vld_r[tbl_idx];
    end
  end

  // player state, updated by the transaction in stage one
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] active_step_r, active_step_nxt;
  logic [COUNT_BITS-1:0] tone_left_r, tone_left_nxt;
  logic [COUNT_BITS:0]   gap_left_r, gap_left_nxt;

  logic [COUNT_BITS-1:0] tone_len;
  logic [COUNT_BITS-1:0] sil_len;
  logic [COUNT_BITS-1:0] sync_len;
  logic [PHASE_BITS-1:0] sym_step;
  logic [PHASE_BITS-1:0] mk_step;
  logic                  busy;
  logic                  tone_tick;
  res_flags_t            s1_flags;

  assign tone_len = COUNT_BITS'(tone_samples_r);
  assign sil_len  = COUNT_BITS'(silence_samples_r);
  assign sync_len = COUNT_BITS'(sync_samples_r);
  assign sym_step = rd_hit_r ? rd_data_r : '0;
  assign mk_step  = (s1_op_r == OP_START) ? PHASE_BITS'(start_step_r)
                                          : PHASE_BITS'(end_step_r);
  assign busy     = (tone_left_r != '0) || (gap_left_r != '0);

  always_comb begin
    phase_nxt       = phase_r;
    active_step_nxt = active_step_r;
    tone_left_nxt   = tone_left_r;
    gap_left_nxt    = gap_left_r;
    tone_tick       = 1'b0;
    s1_flags        = '0;
    case (s1_op_r)
      OP_WRITE: begin
        s1_flags.accepted = s1_range_r;
      end
      OP_SYMBOL: begin
        if (!busy) begin
          s1_flags.accepted = 1'b1;
          if (sym_step != '0) begin
            active_step_nxt = sym_step;
            phase_nxt       = '0;
            tone_left_nxt   = tone_len;
            gap_left_nxt    = {1'b0, sil_len};
          end else begin
            // unmapped code: silence for the whole symbol slot
            tone_left_nxt = '0;
            gap_left_nxt  = {1'b0, tone_len} + {1'b0, sil_len};
          end
        end
      end
      OP_START, OP_END: begin
        if (!busy) begin
          s1_flags.accepted = 1'b1;
          if ((mk_step != '0) && (sync_len != '0)) begin
            active_step_nxt = mk_step;
            phase_nxt       = '0;
            tone_left_nxt   = sync_len;
            gap_left_nxt    = {1'b0, sil_len};
          end
        end
      end
      OP_TICK: begin
        if (tone_left_r != '0) begin
          tone_tick             = 1'b1;
          phase_nxt             = phase_r + active_step_r;
          tone_left_nxt         = tone_left_r - COUNT_BITS'(1);
          s1_flags.sample_valid = 1'b1;
        end else if (gap_left_r != '0) begin
          gap_left_nxt          = gap_left_r - (COUNT_BITS+1)'(1);
          s1_flags.sample_valid = 1'b1;
        end
      end
      default: ;
    endcase
    s1_flags.symbol_last = s1_flags.sample_valid && (tone_left_nxt == '0)
                           && (gap_left_nxt == '0);
    s1_flags.busy_res    = (tone_left_nxt != '0) || (gap_left_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= '0;
      active_step_r <= '0;
      tone_left_r   <= '0;
      gap_left_r    <= '0;
    end else if (adv && s1_v_r) begin
      phase_r       <= phase_nxt;
      active_step_r <= active_step_nxt;
      tone_left_r   <= tone_left_nxt;
      gap_left_r    <= gap_left_nxt;
    end
  end

  // sine path runs in step with stages two and three
  logic signed [SAMPLE_W-1:0] sine_sample;

  ctfsk_sine #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_sine (
    .clk       (clk),
    .en        (adv),
    .tone_in   (tone_tick && s1_v_r),
    .addr_in   (phase_r[PHASE_BITS-1 -: SINE_ADDR_BITS]),
    .amplitude (amplitude_r),
    .sample    (sine_sample)
  );

  logic       s2_v_r, s3_v_r;
  res_flags_t s2_flags_r, s3_flags_r;
  res_flags_t out_flags_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_flags_r   <= s1_flags;
      s3_flags_r   <= s2_flags_r;
      out_flags_r  <= s3_flags_r;
      out_sample_r <= sine_sample;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_sample_valid = out_flags_r.sample_valid;
  assign out_symbol_last  = out_flags_r.symbol_last;
  assign out_accepted     = out_flags_r.accepted;
  assign out_busy_res     = out_flags_r.busy_res;

`include "char_to_tone_fsk_generator_top_assert.svh"

  `CTFSK_ASSERT_NOW(a_silent_unless_valid, out_valid_r && !out_flags_r.sample_valid, out_sample_r == '0, "sample nonzero without sample_valid")
  `CTFSK_ASSERT_NOW(a_last_ends_play, out_valid_r && out_flags_r.symbol_last, out_flags_r.sample_valid && !out_flags_r.busy_res, "symbol_last while still playing")
  `CTFSK_ASSERT_NOW(a_accept_not_tick, out_valid_r && out_flags_r.accepted, !out_flags_r.sample_valid, "accepted and sample_valid together")
  `CTFSK_ASSERT_NEXT(a_phase_advance, adv && s1_v_r && tone_tick, phase_r == $past(phase_r + active_step_r), "phase did not advance on a tone tick")

endmodule
